// ----- rtl/bcs_pkg.sv -----
// bcs_pkg: shared constants, types and the knot helper of the b-spline sampler
// no dependencies; imported by every module of the block
package bcs_pkg;

   localparam int MAX_POINTS = 64;
   localparam int MAX_ORDER  = 8;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int ORDER_W    = 4;
   localparam int COUNT_W    = 7;
   localparam int KNOT_W     = 7;
   localparam int SLOT_W     = 3;
   localparam int COORD_W    = 32;
   localparam int T_W        = 17;
   localparam int FRAC_W     = 16;
   localparam int U_W        = KNOT_W + FRAC_W;
   localparam int BASIS_W    = 31;
   localparam int MUL_W      = 33;
   localparam int PROD_W     = 64;
   localparam int DIVD_W     = 38;
   localparam int DIVS_W     = 7;
   localparam int DIVC_W     = 6;
   localparam int TERM_W     = DIVD_W;
   localparam int ACC_W      = 56;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;

   localparam logic [BASIS_W-1:0] ONE_Q30  = BASIS_W'(1) << 30;
   localparam logic [T_W-1:0]     T_ONE    = T_W'(65536);
   localparam logic [ORDER_W-1:0] ORDER_MAX = ORDER_W'(MAX_ORDER);
   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_POINTS);

   localparam logic REG_ORDER = 1'b0;
   localparam logic REG_COUNT = 1'b1;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   typedef struct packed {
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } point_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // knot numerator over d for the clamped uniform knot vector
   function automatic logic [KNOT_W-1:0] knot_num(input logic [KNOT_W-1:0] idx,
                                                  input logic [ORDER_W-1:0] k,
                                                  input logic [KNOT_W-1:0] n,
                                                  input logic [KNOT_W-1:0] d);
      logic [KNOT_W-1:0] r;
      if (idx < KNOT_W'(k)) begin
         r = '0;
      end else if (idx >= n) begin
         r = d;
      end else begin
         r = idx - KNOT_W'(k) + KNOT_W'(1);
      end
      return r;
   endfunction

endpackage

// ----- rtl/bcs_point_mem.sv -----
// bcs_point_mem: control point table with registered read and per-entry valid bits
// depends on bcs_pkg; unwritten entries read as index << FRAC_W in all coordinates
module bcs_point_mem
   import bcs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  point_type         wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output point_type         rd_data
);

   point_type         mem [MAX_POINTS];
   logic [MAX_POINTS-1:0] valid_ff;
   point_type         mem_q_ff;
   logic              valid_q_ff;
   logic [ADDR_W-1:0] addr_q_ff;
   logic [COORD_W-1:0] dflt;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      mem_q_ff  <= mem[rd_addr];
      addr_q_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         valid_q_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         valid_q_ff <= valid_ff[rd_addr];
      end
   end

   assign dflt = COORD_W'(addr_q_ff) << FRAC_W;

   always_comb begin
      if (valid_q_ff) begin
         rd_data = mem_q_ff;
      end else begin
         rd_data.x = dflt;
         rd_data.y = dflt;
         rd_data.z = dflt;
      end
   end

endmodule

// ----- rtl/bcs_mul.sv -----
// bcs_mul: shared signed multiplier with a registered product
// depends on bcs_pkg
module bcs_mul
   import bcs_pkg::*;
(
   input  logic                     clock,
   input  logic signed [MUL_W-1:0]  op_a,
   input  logic signed [MUL_W-1:0]  op_b,
   output logic signed [PROD_W-1:0] product
);

   logic signed [2*MUL_W-1:0] full;
   logic signed [PROD_W-1:0]  product_ff;

   assign full = op_a * op_b;

   always_ff @(posedge clock) begin
      product_ff <= full[PROD_W-1:0];
   end

   assign product = product_ff;

endmodule

// ----- rtl/bcs_div.sv -----
// bcs_div: restoring divider, one quotient bit per cycle
// depends on bcs_pkg; divides the scaled basis product by a knot span
module bcs_div
   import bcs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DIVS_W-1:0] divisor,
   output div_status_type    status,
   output logic [DIVD_W-1:0] quotient
);

   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVS_W-1:0] dvs_ff, dvs_in;
   logic [DIVC_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIVS_W:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DIVD_W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = DIVC_W'(DIVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DIVS_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DIVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVS_W-1:0];
            quo_in = {quo_ff[DIVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DIVC_W'(1);
         if (cnt_ff == DIVC_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

// ----- rtl/bspline_curve_sample_top.sv -----
// bspline_curve_sample_top: clamped uniform b-spline sampler, sequencer and registers
// depends on bcs_pkg, bcs_point_mem, bcs_mul, bcs_div
//
// usage:
//   req channel: tuser = cmd; tdata from bit 0 up = point_index, point_x,
//   point_y, point_z, param_t. cmd write stores a control point and gives no
//   item on rsp; cmd sample gives one rsp item, tdata = sample_x, sample_y,
//   sample_z from bit 0 up.
//   csr port: 0x0 spline_order, 0x4 point_count; write only while idle.
//   a sample runs over all n control points for order k; every recursion
//   term is formed by the bit-serial divider, two per basis node.
//   req_tready is low while a sample is in work.
//   a finished sample sits in the rsp register; if the receiver stalls with
//   an earlier item still held, the sequencer waits in its last step.
//   reset: order 4, count 5, table entry i holds i << 16 in x, y and z, no item held.
module bspline_curve_sample_top
   import bcs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [119:0]       req_tdata,  // point_index, point_x, point_y, point_z, param_t
   input  logic               req_tuser,  // cmd
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [95:0]        rsp_tdata,  // sample_x, sample_y, sample_z
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [CSR_AW-1:0]  csr_paddr,
   input  logic [CSR_DW-1:0]  csr_pwdata,
   output logic [CSR_DW-1:0]  csr_prdata,
   output logic               csr_pready
);

   typedef enum logic [13:0] {
      S_IDLE   = 14'b00000000000001,
      S_BASE   = 14'b00000000000010,
      S_LEVEL  = 14'b00000000000100,
      S_FMUL   = 14'b00000000001000,
      S_FSTART = 14'b00000000010000,
      S_FWAIT  = 14'b00000000100000,
      S_GMUL   = 14'b00000001000000,
      S_GSTART = 14'b00000010000000,
      S_GWAIT  = 14'b00000100000000,
      S_WX     = 14'b00001000000000,
      S_WY     = 14'b00010000000000,
      S_WZ     = 14'b00100000000000,
      S_WACC   = 14'b01000000000000,
      S_DONE   = 14'b10000000000000
   } state_type;

   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh7FFFFFFF);
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

   state_type state_ff, state_in;
   logic [ORDER_W-1:0] order_ff, order_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [ORDER_W-1:0] k_ff, k_in;
   logic [KNOT_W-1:0]  n_ff, n_in;
   logic [KNOT_W-1:0]  d_ff, d_in;
   logic [SLOT_W-1:0]  deg_ff, deg_in;
   logic [U_W-1:0]     u_ff, u_in;
   logic [ADDR_W-1:0]  c_ff, c_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [SLOT_W-1:0]  lvl_ff, lvl_in;
   logic [BASIS_W-1:0] vals_ff [MAX_ORDER];
   logic [BASIS_W-1:0] vals_in [MAX_ORDER];
   logic [TERM_W-1:0]  term_f_ff, term_f_in;
   logic signed [ACC_W-1:0] acc_x_ff, acc_x_in, acc_y_ff, acc_y_in, acc_z_ff, acc_z_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [95:0]        rsp_data_ff, rsp_data_in;

   logic               req_fire, cfg_write;
   point_type          wr_point, rd_point;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic               div_start;
   logic [DIVS_W-1:0]  div_divisor;
   div_status_type     div_status;
   logic [DIVD_W-1:0]  div_q;

   logic [KNOT_W-1:0]  cc, kn_a, kn_b, kn_e, kn_f;
   logic [U_W-1:0]     a_s, b_s, f_s, top_s, diff_f, diff_g;
   logic [KNOT_W-1:0]  m_f, m_g;
   logic               in_span, active, last_slot, last_level;
   logic               shift_en;
   logic [BASIS_W-1:0] shift_val;
   logic [TERM_W:0]    term_sum;
   logic [BASIS_W-1:0] clamped;
   logic signed [PROD_W-1:0] prod_rnd;
   logic signed [ACC_W-1:0]  prod_q;

   logic [ORDER_W-1:0] new_k;
   logic [KNOT_W-1:0]  new_n;
   logic [T_W-1:0]     t_clamp;

   function automatic logic [COORD_W-1:0] finish(input logic signed [ACC_W-1:0] a);
      logic signed [ACC_W-1:0] r;
      r = (a + (a[ACC_W-1] ? ACC_W'(65535) : ACC_W'(0))) >>> FRAC_W;
      if (r > SAT_HI) begin
         r = SAT_HI;
      end else if (r < SAT_LO) begin
         r = SAT_LO;
      end
      return r[COORD_W-1:0];
   endfunction

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_paddr[2])
         REG_ORDER: csr_prdata = CSR_DW'(order_ff);
         REG_COUNT: csr_prdata = CSR_DW'(count_ff);
         default:   csr_prdata = '0;
      endcase
   end

   assign wr_point.x = req_tdata[37:6];
   assign wr_point.y = req_tdata[69:38];
   assign wr_point.z = req_tdata[101:70];

   bcs_point_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_fire && (req_tuser == CMD_WRITE)),
      .wr_addr (req_tdata[ADDR_W-1:0]),
      .wr_data (wr_point),
      .rd_addr (c_ff),
      .rd_data (rd_point)
   );

   bcs_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   bcs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mul_p[FRAC_W+DIVD_W-1:FRAC_W]),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_q)
   );

   // knots of the current node
   assign cc    = KNOT_W'(c_ff) + KNOT_W'(slot_ff);
   assign kn_a  = knot_num(cc, k_ff, n_ff, d_ff);
   assign kn_e  = knot_num(cc + KNOT_W'(1), k_ff, n_ff, d_ff);
   assign kn_b  = knot_num(cc + KNOT_W'(lvl_ff), k_ff, n_ff, d_ff);
   assign kn_f  = knot_num(cc + KNOT_W'(lvl_ff) + KNOT_W'(1), k_ff, n_ff, d_ff);
   assign a_s   = {kn_a, FRAC_W'(0)};
   assign b_s   = {kn_e, FRAC_W'(0)};
   assign f_s   = {kn_f, FRAC_W'(0)};
   assign top_s = {d_ff, FRAC_W'(0)};
   assign diff_f = u_ff - a_s;
   assign diff_g = f_s - u_ff;
   assign m_f   = (kn_b == kn_a) ? d_ff : kn_b - kn_a;
   assign m_g   = (kn_f == kn_e) ? d_ff : kn_f - kn_e;
   // base interval is [knot cc, knot cc+1), closed at the top knot
   assign in_span = (u_ff >= a_s && u_ff < b_s) ||
                    (u_ff == top_s && b_s == top_s && a_s < top_s);
   assign active     = (slot_ff <= deg_ff - lvl_ff);
   assign last_slot  = (slot_ff == deg_ff);
   assign last_level = (lvl_ff == deg_ff);

   assign term_sum = {1'b0, term_f_ff} + {1'b0, div_q};
   assign clamped  = (term_sum > (TERM_W+1)'(ONE_Q30)) ? ONE_Q30 : term_sum[BASIS_W-1:0];

   assign prod_rnd = (mul_p + (mul_p[PROD_W-1] ? PROD_W'(16383) : PROD_W'(0))) >>> 14;
   assign prod_q   = prod_rnd[ACC_W-1:0];

   assign t_clamp = (req_tdata[118:102] > T_ONE) ? T_ONE : req_tdata[118:102];

   always_comb begin
      new_k = order_ff;
      if (order_ff == '0) begin
         new_k = ORDER_W'(1);
      end else if (order_ff > ORDER_MAX) begin
         new_k = ORDER_MAX;
      end
      new_n = (count_ff > COUNT_MAX) ? KNOT_W'(COUNT_MAX) : KNOT_W'(count_ff);
      if (new_n <= KNOT_W'(new_k)) begin
         new_n = KNOT_W'(new_k) + KNOT_W'(1);
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      div_start   = 1'b0;
      div_divisor = m_f;
      case (state_ff)
         S_FMUL: begin
            mul_a = MUL_W'(diff_f);
            mul_b = MUL_W'(vals_ff[0]);
         end
         S_GMUL: begin
            mul_a = MUL_W'(diff_g);
            mul_b = MUL_W'(vals_ff[1]);
         end
         S_FSTART: begin
            div_start   = 1'b1;
            div_divisor = m_f;
         end
         S_GSTART: begin
            div_start   = 1'b1;
            div_divisor = m_g;
         end
         S_WX: begin
            mul_a = MUL_W'(vals_ff[0]);
            mul_b = MUL_W'(rd_point.x);
         end
         S_WY: begin
            mul_a = MUL_W'(vals_ff[0]);
            mul_b = MUL_W'(rd_point.y);
         end
         S_WZ: begin
            mul_a = MUL_W'(vals_ff[0]);
            mul_b = MUL_W'(rd_point.z);
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      order_in  = order_ff;
      count_in  = count_ff;
      k_in      = k_ff;
      n_in      = n_ff;
      d_in      = d_ff;
      deg_in    = deg_ff;
      u_in      = u_ff;
      c_in      = c_ff;
      slot_in   = slot_ff;
      lvl_in    = lvl_ff;
      term_f_in = term_f_ff;
      acc_x_in  = acc_x_ff;
      acc_y_in  = acc_y_ff;
      acc_z_in  = acc_z_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      shift_en  = 1'b0;
      shift_val = vals_ff[0];

      if (cfg_write) begin
         case (csr_paddr[2])
            REG_ORDER: order_in = csr_pwdata[ORDER_W-1:0];
            REG_COUNT: count_in = csr_pwdata[COUNT_W-1:0];
            default:   order_in = order_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire && req_tuser == CMD_SAMPLE) begin
               k_in     = new_k;
               n_in     = new_n;
               d_in     = new_n - KNOT_W'(new_k) + KNOT_W'(1);
               deg_in   = SLOT_W'(new_k - ORDER_W'(1));
               u_in     = U_W'(t_clamp) * U_W'(new_n - KNOT_W'(new_k) + KNOT_W'(1));
               c_in     = '0;
               slot_in  = '0;
               lvl_in   = '0;
               acc_x_in = '0;
               acc_y_in = '0;
               acc_z_in = '0;
               state_in = S_BASE;
            end
         end
         S_BASE: begin
            shift_en  = 1'b1;
            shift_val = in_span ? ONE_Q30 : '0;
            if (last_slot) begin
               slot_in = '0;
               if (deg_ff == '0) begin
                  state_in = S_WX;
               end else begin
                  lvl_in   = SLOT_W'(1);
                  state_in = S_LEVEL;
               end
            end else begin
               slot_in = slot_ff + SLOT_W'(1);
            end
         end
         S_LEVEL: begin
            if (active) begin
               state_in = S_FMUL;
            end else begin
               shift_en = 1'b1;
               if (last_slot) begin
                  slot_in = '0;
                  if (last_level) begin
                     state_in = S_WX;
                  end else begin
                     lvl_in = lvl_ff + SLOT_W'(1);
                  end
               end else begin
                  slot_in = slot_ff + SLOT_W'(1);
               end
            end
         end
         S_FMUL:   state_in = S_FSTART;
         S_FSTART: state_in = S_FWAIT;
         S_FWAIT: begin
            if (div_status.done) begin
               term_f_in = div_q;
               state_in  = S_GMUL;
            end
         end
         S_GMUL:   state_in = S_GSTART;
         S_GSTART: state_in = S_GWAIT;
         S_GWAIT: begin
            if (div_status.done) begin
               shift_en  = 1'b1;
               shift_val = clamped;
               state_in  = S_LEVEL;
               if (last_slot) begin
                  slot_in = '0;
                  if (last_level) begin
                     state_in = S_WX;
                  end else begin
                     lvl_in = lvl_ff + SLOT_W'(1);
                  end
               end else begin
                  slot_in = slot_ff + SLOT_W'(1);
               end
            end
         end
         S_WX: state_in = S_WY;
         S_WY: begin
            acc_x_in = acc_x_ff + prod_q;
            state_in = S_WZ;
         end
         S_WZ: begin
            acc_y_in = acc_y_ff + prod_q;
            state_in = S_WACC;
         end
         S_WACC: begin
            acc_z_in = acc_z_ff + prod_q;
            if (KNOT_W'(c_ff) == n_ff - KNOT_W'(1)) begin
               state_in = S_DONE;
            end else begin
               c_in     = c_ff + ADDR_W'(1);
               slot_in  = '0;
               lvl_in   = '0;
               state_in = S_BASE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {finish(acc_z_ff), finish(acc_y_ff), finish(acc_x_ff)};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // shift the basis slots down one place, new value enters at slot deg
   always_comb begin
      for (int p = 0; p < MAX_ORDER; p++) begin
         vals_in[p] = vals_ff[p];
         if (shift_en) begin
            if (SLOT_W'(p) == deg_ff) begin
               vals_in[p] = shift_val;
            end else if (p < MAX_ORDER - 1) begin
               vals_in[p] = vals_ff[p+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      n_ff      <= n_in;
      d_ff      <= d_in;
      deg_ff    <= deg_in;
      u_ff      <= u_in;
      c_ff      <= c_in;
      slot_ff   <= slot_in;
      lvl_ff    <= lvl_in;
      term_f_ff <= term_f_in;
      acc_x_ff  <= acc_x_in;
      acc_y_ff  <= acc_y_in;
      acc_z_ff  <= acc_z_in;
      rsp_data_ff <= rsp_data_in;
      for (int p = 0; p < MAX_ORDER; p++) begin
         vals_ff[p] <= vals_in[p];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         order_ff     <= ORDER_W'(4);
         count_ff     <= COUNT_W'(5);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         order_ff     <= order_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BASE || state_ff == S_LEVEL) |-> slot_ff <= deg_ff)
      else $error("basis slot beyond degree");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LEVEL) |-> (lvl_ff >= SLOT_W'(1) && lvl_ff <= deg_ff))
      else $error("recursion level out of range");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while busy");

   a_basis_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WX) |-> vals_ff[0] <= ONE_Q30)
      else $error("basis weight above one");

   a_done_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !rsp_valid_ff) |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("finished sample not loaded");

endmodule
